// ----- rtl/core/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define MMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define MMS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/mms_pkg.sv -----
// ---------------------------------------------------------------------------
// mms_pkg
// Field layout, register indexes and fixed constants of the scheduler.
// ---------------------------------------------------------------------------
package mms_pkg;

    localparam int MACHINE_W  = 3;
    localparam int FIELD_TW   = 32;
    localparam int RATIO_W    = 17;
    localparam int FRAC_W     = 16;

    typedef logic [RATIO_W-1:0] ratio_t;

    // Q1.16 value of one
    localparam ratio_t QONE = ratio_t'(65536);

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = RATIO_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_RATIO_LOW  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RATIO_HIGH = 2'd1;

    localparam ratio_t RATIO_LOW_RST  = ratio_t'(39322);
    localparam ratio_t RATIO_HIGH_RST = ratio_t'(58982);

    // input tdata: machine_index, exec_time, dep_ready
    localparam int S_IDX_LSB  = 0;
    localparam int S_EXEC_LSB = S_IDX_LSB + MACHINE_W;
    localparam int S_DEP_LSB  = S_EXEC_LSB + FIELD_TW;
    localparam int S_TDATA_W  = 72;

    // output tdata: chosen_machine, completion_time, execution_time, mode_after
    localparam int M_IDX_LSB  = 0;
    localparam int M_COMP_LSB = M_IDX_LSB + MACHINE_W;
    localparam int M_EXEC_LSB = M_COMP_LSB + FIELD_TW;
    localparam int M_MODE_BIT = M_EXEC_LSB + FIELD_TW;
    localparam int M_TDATA_W  = 72;

endpackage

// ----- rtl/core/mms_ram.sv -----
// ---------------------------------------------------------------------------
// mms_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module mms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/mct_met_switching_scheduler.sv -----
// ---------------------------------------------------------------------------
// mct_met_switching_scheduler
// MCT/MET switching task-to-machine scheduler with RAM-held ready times.
// ---------------------------------------------------------------------------
// One transfer per machine describes a task; the transfer with tlast closes
// it and yields one result. Machine ready times sit in a registered-read RAM
// with a reset-cleared valid bit per entry, so no clearing pass is run. A
// transfer without tlast goes through a RAM read, then evaluate. A transfer
// with tlast that finds an allowed machine runs evaluate, write back, a sweep
// through the RAM for min/max ready time, the high and low products of the
// shared threshold multiplier, a mode decision and the result load before
// the next transfer is taken; with no allowed machine it goes from evaluate
// to the result load. The result load waits for as long as the previous
// result is still held by the receiver. The result waits in an output
// register while new transfers are accepted. initial_mode only acts through
// reset, which returns it to MCT, so a write to it has no effect.
// ---------------------------------------------------------------------------
module mct_met_switching_scheduler
    import mms_pkg::*;
#(
    parameter int MACHINES  = 8,
    parameter int TIME_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    // machine_index[2:0], exec_time[34:3], dep_ready[66:35], zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // machine_allowed[0]
    input  logic [0:0]            s_tuser,
    input  logic                  s_tlast,

    output logic                  m_tvalid,
    input  logic                  m_tready,
    // chosen_machine[2:0], completion_time[34:3], execution_time[66:35],
    // mode_after[67], zero fill
    output logic [M_TDATA_W-1:0]  m_tdata,
    // no_valid_machine[0]
    output logic [0:0]            m_tuser
);

    localparam int TW  = TIME_BITS;
    localparam int AW  = (MACHINES > 1) ? $clog2(MACHINES) : 1;
    localparam int IXW = AW + MACHINE_W;
    localparam int CW  = $clog2(MACHINES + 1);
    localparam int PW  = TW + RATIO_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EVAL   = 3'd1;
    localparam logic [2:0] ST_COMMIT = 3'd2;
    localparam logic [2:0] ST_SWEEP  = 3'd3;
    localparam logic [2:0] ST_MUL_HI = 3'd4;
    localparam logic [2:0] ST_MUL_LO = 3'd5;
    localparam logic [2:0] ST_DECIDE = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]           state_reg;
    ratio_t               ratio_low_reg;
    ratio_t               ratio_high_reg;
    logic                 mode_reg;

    logic                 item_ok_reg;
    logic [MACHINE_W-1:0] item_idx_reg;
    logic [TW-1:0]        item_ex_reg;
    logic [TW-1:0]        item_dep_reg;
    logic                 item_last_reg;

    logic                 best_found_reg;
    logic [MACHINE_W-1:0] best_machine_reg;
    logic [TW-1:0]        best_comp_reg;
    logic [TW-1:0]        best_exec_reg;

    logic [MACHINES-1:0]  valid_reg;
    logic                 rd_valid_reg;
    logic [CW-1:0]        sweep_cnt_reg;
    logic                 sweep_pend_reg;
    logic [TW-1:0]        lo_reg;
    logic [TW-1:0]        hi_reg;
    logic [PW-1:0]        prod_reg;
    logic                 met_hit_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    logic                 s_accept;
    logic [IXW-1:0]       in_idx_wide;
    logic                 in_range;
    logic [IXW-1:0]       best_idx_wide;
    logic                 sweep_issue;
    logic                 ram_we;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [AW-1:0]        ram_waddr;
    logic [TW-1:0]        ram_rdata;
    logic [TW-1:0]        rt_eff;
    logic [TW-1:0]        start_time;
    logic [TW:0]          sum_time;
    logic [TW-1:0]        comp_time;
    logic                 take;
    logic                 out_free;
    logic [PW-1:0]        lo_scaled;
    logic [PW-1:0]        mul_a;
    logic [M_TDATA_W-1:0] result_data;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign in_idx_wide   = IXW'(s_tdata[S_IDX_LSB +: MACHINE_W]);
    assign in_range      = in_idx_wide < IXW'(MACHINES);
    assign best_idx_wide = IXW'(best_machine_reg);
    assign sweep_issue   = (state_reg == ST_SWEEP) && (sweep_cnt_reg < CW'(MACHINES));

    assign ram_re    = s_accept || sweep_issue;
    assign ram_raddr = (state_reg == ST_IDLE) ? in_idx_wide[AW-1:0] : sweep_cnt_reg[AW-1:0];
    assign ram_we    = (state_reg == ST_COMMIT);
    assign ram_waddr = best_idx_wide[AW-1:0];

    mms_ram #(
        .WIDTH (TW),
        .DEPTH (MACHINES)
    ) u_ready_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (best_comp_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rt_eff     = rd_valid_reg ? ram_rdata : '0;
    assign start_time = (item_dep_reg > rt_eff) ? item_dep_reg : rt_eff;
    assign sum_time   = {1'b0, start_time} + {1'b0, item_ex_reg};
    assign comp_time  = sum_time[TW] ? '1 : sum_time[TW-1:0];

    assign take = item_ok_reg &&
                  (!best_found_reg ||
                   (!mode_reg && (comp_time < best_comp_reg)) ||
                   (mode_reg && (item_ex_reg < best_exec_reg)));

    assign out_free  = !m_tvalid_reg || m_tready;
    assign lo_scaled = PW'({lo_reg, {FRAC_W{1'b0}}});
    assign mul_a     = (state_reg == ST_MUL_HI) ? PW'(ratio_high_reg) : PW'(ratio_low_reg);

    always_comb begin
        result_data = '0;
        if (best_found_reg) begin
            result_data[M_IDX_LSB +: MACHINE_W] = best_machine_reg;
            result_data[M_COMP_LSB +: FIELD_TW] = FIELD_TW'(best_comp_reg);
            result_data[M_EXEC_LSB +: FIELD_TW] = FIELD_TW'(best_exec_reg);
        end
        result_data[M_MODE_BIT] = mode_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_low_reg  <= RATIO_LOW_RST;
            ratio_high_reg <= RATIO_HIGH_RST;
        end else if (cfg_wr_en) begin
            if (cfg_addr == CFG_RATIO_LOW) begin
                ratio_low_reg <= cfg_wdata;
            end
            if (cfg_addr == CFG_RATIO_HIGH) begin
                ratio_high_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            rd_valid_reg <= valid_reg[ram_raddr];
        end

        if (s_accept) begin
            item_ok_reg   <= s_tuser[0] && in_range;
            item_idx_reg  <= s_tdata[S_IDX_LSB +: MACHINE_W];
            item_ex_reg   <= TW'(s_tdata[S_EXEC_LSB +: FIELD_TW]);
            item_dep_reg  <= TW'(s_tdata[S_DEP_LSB +: FIELD_TW]);
            item_last_reg <= s_tlast;
        end

        if ((state_reg == ST_EVAL) && take) begin
            best_machine_reg <= item_idx_reg;
            best_comp_reg    <= comp_time;
            best_exec_reg    <= item_ex_reg;
        end

        unique case (state_reg)
            ST_COMMIT: begin
                lo_reg <= '1;
                hi_reg <= '0;
            end
            ST_SWEEP: begin
                if (sweep_pend_reg) begin
                    if (rt_eff < lo_reg) begin
                        lo_reg <= rt_eff;
                    end
                    if (rt_eff > hi_reg) begin
                        hi_reg <= rt_eff;
                    end
                end
            end
            ST_MUL_HI: begin
                prod_reg <= mul_a * PW'(hi_reg);
            end
            ST_MUL_LO: begin
                met_hit_reg <= (ratio_high_reg <= QONE) && (lo_scaled >= prod_reg);
                prod_reg    <= mul_a * PW'(hi_reg);
            end
            default: begin
            end
        endcase

        if ((state_reg == ST_DONE) && out_free) begin
            m_tdata_reg <= result_data;
            m_tuser_reg <= !best_found_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            mode_reg       <= 1'b0;
            best_found_reg <= 1'b0;
            valid_reg      <= '0;
            sweep_cnt_reg  <= '0;
            sweep_pend_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if ((state_reg == ST_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        state_reg <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    if (take) begin
                        best_found_reg <= 1'b1;
                    end
                    if (!item_last_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (best_found_reg || take) begin
                        state_reg <= ST_COMMIT;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_COMMIT: begin
                    valid_reg[ram_waddr] <= 1'b1;
                    sweep_cnt_reg        <= '0;
                    sweep_pend_reg       <= 1'b0;
                    state_reg            <= ST_SWEEP;
                end
                ST_SWEEP: begin
                    sweep_pend_reg <= sweep_issue;
                    if (sweep_issue) begin
                        sweep_cnt_reg <= sweep_cnt_reg + CW'(1);
                    end else if (!sweep_pend_reg) begin
                        state_reg <= ST_MUL_HI;
                    end
                end
                ST_MUL_HI: begin
                    state_reg <= ST_MUL_LO;
                end
                ST_MUL_LO: begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (hi_reg != '0) begin
                        if (met_hit_reg) begin
                            mode_reg <= 1'b1;
                        end else if ((ratio_low_reg > QONE) || (lo_scaled <= prod_reg)) begin
                            mode_reg <= 1'b0;
                        end
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        best_found_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/mms_checker.sv -----
// ---------------------------------------------------------------------------
// mms_checker
// Port-level checks of the scheduler, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mms_checker
    import mms_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [0:0]           m_tuser
);

    logic s_xfer;

    assign s_xfer = s_tvalid && s_tready;

    // a result without a machine carries no machine, completion or execution time
    `MMS_ASSERT_IMP(a_no_valid_zero, aclk, aresetn, m_tvalid && m_tuser[0], m_tdata[M_MODE_BIT-1:0] == '0, "no-valid result carries nonzero fields")

    // an accepted transfer is evaluated before the next one is taken
    `MMS_ASSERT_NXT(a_busy_after_xfer, aclk, aresetn, s_xfer, !s_tready, "input taken during evaluation")

    // no result is loaded in the cycle that evaluates a transfer
    `MMS_ASSERT_NXT(a_no_early_result, aclk, aresetn, s_xfer, !$rose(m_tvalid), "result appeared during evaluation")

    // hold a stalled result
    `MMS_ASSERT_NXT(a_hold_stalled, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind mct_met_switching_scheduler mms_checker u_mms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MCT/MET switching scheduler. Estimate
// transfers are built per task and driven in random bursts; an in-bench
// model of the machine ready times, the best-machine search and the
// ratio-driven mode switch predicts each assignment, which is compared
// field by field with the result stream under a randomly stalling receiver.
// Threshold registers are swept through their extremes between phases.
// ---------------------------------------------------------------------------
module tb_top;
    import mms_pkg::*;

    localparam int MACHINES      = 8;
    localparam int SETTLE_CYCLES = MACHINES + 16;
    localparam int STALL_LIMIT   = 4000;
    localparam int LONG_HOLD     = 400;

    localparam logic [CFG_ADDR_W-1:0] CFG_INITIAL_MODE = 2'd2;
    localparam logic                  MODE_MCT         = 1'b0;
    localparam logic                  MODE_MET         = 1'b1;
    localparam logic [FIELD_TW-1:0]   TIME_MAX         = '1;
    localparam ratio_t                RATIO_ALL_ONES   = '1;

    typedef struct packed {
        logic [MACHINE_W-1:0] machine;
        logic                 allowed;
        logic [FIELD_TW-1:0]  exec_t;
        logic [FIELD_TW-1:0]  dep_ready;
        logic                 last;
    } estimate_t;

    typedef struct packed {
        logic [MACHINE_W-1:0] machine;
        logic [FIELD_TW-1:0]  completion;
        logic [FIELD_TW-1:0]  exec_t;
        logic                 mode;
        logic                 no_valid;
    } assignment_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;

    mct_met_switching_scheduler #(
        .MACHINES  (MACHINES),
        .TIME_BITS (FIELD_TW)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 aclk = ~aclk;

    // scheduler model state
    logic [FIELD_TW-1:0]  ready_time [MACHINES] = '{default: '0};
    logic                 mode_flag       = MODE_MCT;
    logic [MACHINE_W-1:0] best_machine    = '0;
    logic [FIELD_TW-1:0]  best_completion = '0;
    logic [FIELD_TW-1:0]  best_exec       = '0;
    logic                 best_found      = 1'b0;
    ratio_t               thr_low         = RATIO_LOW_RST;
    ratio_t               thr_high        = RATIO_HIGH_RST;
    logic                 init_mode_reg   = MODE_MCT;

    estimate_t   pending_items[$];
    assignment_t expected_assignments[$];
    int          items_queued   = 0;
    int          items_accepted = 0;
    int          mismatch_count = 0;

    logic [FIELD_TW-1:0] time_base   = '0;
    bit                  wide_values = 1'b0;

    function automatic void refresh_mode();
        logic [63:0] lo;
        logic [63:0] hi;
        lo = 64'(ready_time[0]);
        hi = 64'(ready_time[0]);
        for (int m = 1; m < MACHINES; m++) begin
            if (64'(ready_time[m]) < lo) lo = 64'(ready_time[m]);
            if (64'(ready_time[m]) > hi) hi = 64'(ready_time[m]);
        end
        if (hi == 0) return;
        if (thr_high <= QONE && lo * 64'(QONE) >= 64'(thr_high) * hi) begin
            mode_flag = MODE_MET;
        end else if (thr_low > QONE || lo * 64'(QONE) <= 64'(thr_low) * hi) begin
            mode_flag = MODE_MCT;
        end
    endfunction

    function automatic void predict_assignment(estimate_t it);
        logic [FIELD_TW-1:0] start;
        logic [FIELD_TW:0]   sum;
        logic [FIELD_TW-1:0] comp;
        assignment_t         res;
        if (it.allowed) begin
            start = (it.dep_ready > ready_time[it.machine]) ? it.dep_ready
                                                            : ready_time[it.machine];
            sum  = {1'b0, start} + {1'b0, it.exec_t};
            comp = sum[FIELD_TW] ? TIME_MAX : sum[FIELD_TW-1:0];
            if (!best_found ||
                (mode_flag == MODE_MCT && comp < best_completion) ||
                (mode_flag == MODE_MET && it.exec_t < best_exec)) begin
                best_found      = 1'b1;
                best_machine    = it.machine;
                best_completion = comp;
                best_exec       = it.exec_t;
            end
        end
        if (it.last) begin
            res = '0;
            if (best_found) begin
                ready_time[best_machine] = best_completion;
                refresh_mode();
                res.machine    = best_machine;
                res.completion = best_completion;
                res.exec_t     = best_exec;
            end else begin
                res.no_valid = 1'b1;
            end
            res.mode = mode_flag;
            expected_assignments.insert(expected_assignments.size(), res);
            best_found      = 1'b0;
            best_machine    = '0;
            best_completion = '0;
            best_exec       = '0;
        end
    endfunction

    function automatic void queue_estimate(logic [MACHINE_W-1:0] machine, logic allowed,
                                           logic [FIELD_TW-1:0] exec_t,
                                           logic [FIELD_TW-1:0] dep_ready, logic last);
        estimate_t it;
        it.machine   = machine;
        it.allowed   = allowed;
        it.exec_t    = exec_t;
        it.dep_ready = dep_ready;
        it.last      = last;
        pending_items.insert(pending_items.size(), it);
        items_queued++;
    endfunction

    function automatic logic [FIELD_TW-1:0] pick_exec();
        int roll;
        roll = $urandom_range(99);
        if (wide_values && roll < 3) return $urandom;
        if (roll < 6) return '0;
        if (roll < 40) return $urandom_range(1, 40);
        return $urandom_range(1, 2000);
    endfunction

    function automatic logic [FIELD_TW-1:0] pick_dep();
        int roll;
        roll = $urandom_range(99);
        if (wide_values && roll < 3) return $urandom;
        if (roll < 10) return '0;
        return time_base + $urandom_range(0, 200);
    endfunction

    // mostly full machine sweeps; the rest short or repeated-index tasks
    function automatic void queue_random_task();
        int                   n;
        bit                   sweep;
        bit                   none_allowed;
        bit                   shared_dep;
        logic [FIELD_TW-1:0]  dep;
        logic [MACHINE_W-1:0] idx;
        sweep        = ($urandom_range(9) < 7);
        n            = sweep ? MACHINES : $urandom_range(1, 10);
        none_allowed = ($urandom_range(19) == 0);
        shared_dep   = ($urandom_range(9) != 0);
        dep          = pick_dep();
        for (int i = 0; i < n; i++) begin
            idx = sweep ? MACHINE_W'(i) : MACHINE_W'($urandom_range(MACHINES - 1));
            queue_estimate(idx, !none_allowed && ($urandom_range(4) != 0), pick_exec(),
                           shared_dep ? dep : pick_dep(), i == n - 1);
        end
        time_base += $urandom_range(0, 300);
    endfunction

    function automatic void queue_random_tasks(int count);
        int target;
        target = items_queued + count;
        while (items_queued < target) queue_random_task();
    endfunction

    task automatic wait_idle();
        while (items_accepted != items_queued || expected_assignments.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, ratio_t data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        case (addr)
            CFG_RATIO_LOW:    thr_low = data;
            CFG_RATIO_HIGH:   thr_high = data;
            CFG_INITIAL_MODE: init_mode_reg = data[0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void check_field(string name, logic [FIELD_TW-1:0] want,
                                        logic [FIELD_TW-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // driver: bursts of transfers separated by random gaps
    estimate_t cur_item;
    int        burst_left = 0;
    int        gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                predict_assignment(cur_item);
                items_accepted++;
            end
            if (gap_left != 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                cur_item = pending_items.pop_front();
                s_tdata  <= {{(S_TDATA_W - S_DEP_LSB - FIELD_TW){1'b0}},
                             cur_item.dep_ready, cur_item.exec_t, cur_item.machine};
                s_tuser  <= cur_item.allowed;
                s_tlast  <= cur_item.last;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall rate changes per segment; long hold-offs at fixed result counts
    int rx_seen    = 0;
    int hold_left  = 0;
    int seg_left   = 0;
    int stall_pct  = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                rx_seen++;
                if (rx_seen == 30 || rx_seen == 180) hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(20, 120);
                    case ($urandom_range(4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 30;
                        3:       stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                seg_left--;
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        assignment_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_assignments.size() == 0) begin
                $display("%0t: unexpected result: expected none actual tdata %h tuser %b",
                         $time, m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = expected_assignments.pop_front();
                check_field("chosen_machine", FIELD_TW'(want.machine),
                            FIELD_TW'(m_tdata[M_IDX_LSB +: MACHINE_W]));
                check_field("completion_time", want.completion,
                            m_tdata[M_COMP_LSB +: FIELD_TW]);
                check_field("execution_time", want.exec_t, m_tdata[M_EXEC_LSB +: FIELD_TW]);
                check_field("mode_after", FIELD_TW'(want.mode), FIELD_TW'(m_tdata[M_MODE_BIT]));
                check_field("no_valid_machine", FIELD_TW'(want.no_valid),
                            FIELD_TW'(m_tuser[0]));
            end
        end
    end

    // watchdog
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            idle_cycles <= 0;
        end else if (idle_cycles == STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // zero completion: all ready times stay zero, mode held
        queue_estimate(3'd0, 1'b1, '0, '0, 1'b1);
        // no machine allowed
        queue_estimate(3'd3, 1'b0, 100, '0, 1'b0);
        queue_estimate(3'd5, 1'b0, 200, '0, 1'b1);
        // full sweep, machines 2 and 5 tie: keep the first
        queue_estimate(3'd0, 1'b1, 40, '0, 1'b0);
        queue_estimate(3'd1, 1'b1, 30, '0, 1'b0);
        queue_estimate(3'd2, 1'b1, 12, '0, 1'b0);
        queue_estimate(3'd3, 1'b1, 50, '0, 1'b0);
        queue_estimate(3'd4, 1'b1, 60, '0, 1'b0);
        queue_estimate(3'd5, 1'b1, 12, '0, 1'b0);
        queue_estimate(3'd6, 1'b1, 70, '0, 1'b0);
        queue_estimate(3'd7, 1'b1, 80, '0, 1'b1);
        // same machine named twice
        queue_estimate(3'd4, 1'b1, 50, 10, 1'b0);
        queue_estimate(3'd4, 1'b1, 30, 10, 1'b0);
        queue_estimate(3'd6, 1'b1, 45, 10, 1'b1);
        // single-transfer task
        queue_estimate(3'd7, 1'b1, 1, '0, 1'b1);
        // closing transfer not allowed
        queue_estimate(3'd1, 1'b1, 10, 20, 1'b0);
        queue_estimate(3'd2, 1'b0, 5, '0, 1'b1);
        queue_random_tasks(150);
        wait_idle();

        // zero thresholds: any ratio selects MET while a ready time is nonzero
        write_reg(CFG_INITIAL_MODE, ratio_t'(1));
        write_reg(CFG_RATIO_HIGH, '0);
        write_reg(CFG_RATIO_LOW, '0);
        queue_random_tasks(300);
        wait_idle();

        // MET only on fully balanced machines
        write_reg(CFG_RATIO_LOW, QONE);
        write_reg(CFG_RATIO_HIGH, QONE);
        queue_random_tasks(300);
        wait_idle();

        // thresholds above one: never MET, always MCT
        write_reg(CFG_RATIO_LOW, RATIO_ALL_ONES);
        write_reg(CFG_RATIO_HIGH, RATIO_ALL_ONES);
        queue_random_tasks(250);
        wait_idle();

        for (int p = 0; p < 3; p++) begin
            write_reg(CFG_RATIO_LOW, ratio_t'($urandom_range(0, QONE)));
            write_reg(CFG_RATIO_HIGH, ratio_t'($urandom_range(0, QONE)));
            queue_random_tasks(250);
            wait_idle();
        end

        // back to reset thresholds with wide values, then saturate
        write_reg(CFG_RATIO_LOW, RATIO_LOW_RST);
        write_reg(CFG_RATIO_HIGH, RATIO_HIGH_RST);
        write_reg(CFG_INITIAL_MODE, ratio_t'(0));
        wide_values = 1'b1;
        queue_random_tasks(250);
        for (int m = 0; m < MACHINES; m++)
            queue_estimate(MACHINE_W'(m), 1'b1, TIME_MAX, TIME_MAX, m == MACHINES - 1);
        queue_estimate(3'd3, 1'b1, TIME_MAX, '0, 1'b1);
        queue_estimate(3'd5, 1'b1, '0, TIME_MAX, 1'b1);
        queue_estimate(3'd6, 1'b0, TIME_MAX, TIME_MAX, 1'b0);
        queue_estimate(3'd7, 1'b1, 1, 5, 1'b1);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
